// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the classified signed distance core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSD_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication check failed");
`define CSD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("invariant check failed");
`else
`define CSD_ASSERT_IMPLIES(lbl, ante, cons)
`define CSD_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

// ===== hw/rtl/csd_pkg.sv =====
// Types and constants of the classified signed distance core.
package csd_pkg;
	localparam int MAX_SEGMENTS = 1024;
	localparam int MAX_CELLS    = 1024;
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int T_FRAC       = 30;
	localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

	localparam logic [1:0] REQ_SEG   = 2'd0;
	localparam logic [1:0] REQ_CELL  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic CFG_SEG_COUNT  = 1'b0;
	localparam logic CFG_CELL_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [IDX_W-1:0]   entry_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic               label_negative;
		logic               known_cell;
	} req_t;

	typedef struct packed {
		logic signed [31:0] signed_distance;
		logic               index_error;
	} result_t;
endpackage

// ===== hw/rtl/classified_signed_distance_core.sv =====
// Classified signed distance core: segment and centroid tables with a pipelined search.
// A query walks both tables, max(segment_count, cell_count) entries: the walk feeds one table
// entry per cycle into the segment and centroid pipelines (one memory read port each), then
// the pipelines drain, a 32-step square root runs and the result is registered at the output.
// One query is in flight at a time. Reset clears control and sets both counts to 1; the
// tables are not cleared, write an entry before use.
module classified_signed_distance_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  csd_pkg::req_t     in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output csd_pkg::result_t  out_word,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [10:0]       cfg_data
);
	import csd_pkg::*;
`include "assert_macros.svh"

	localparam int DIV_STEPS = T_FRAC;

	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_ROOT, ST_DONE} state_t;

	state_t state_q;
	logic [CNT_W-1:0] seg_count_q, cell_count_q, seg_n, cell_n, walk_len, cnt_q;
	logic in_acc;
	logic signed [31:0] px_q, py_q;
	logic [IDX_W-1:0] qidx_q;
	logic known_q, err_q;

	// table storage
	logic [127:0] seg_mem [MAX_SEGMENTS];
	logic [64:0]  cell_mem [MAX_CELLS];

	// segment pipeline
	logic          v_s1, v_s2, v_s3, v_s4;
	logic [127:0]  rd_s1;
	logic [31:0]   mvx_s2, mvy_s2, mwx_s2, mwy_s2;
	logic          svx_s2, svy_s2, swx_s2, swy_s2;
	logic signed [32:0] wx_s2, wy_s2, wx_s3, wy_s3, wx_s4, wy_s4;
	logic [63:0]   lxx_s3, lyy_s3, p1_s3, p2_s3;
	logic          n1_s3, n2_s3;
	logic [31:0]   mvx_s3, mvy_s3, mvx_s4, mvy_s4;
	logic          svx_s3, svy_s3, svx_s4, svy_s4;
	logic [64:0]   len_s4;
	logic signed [66:0] dot_s4;

	// divider stages: entry 0 holds the setup, entry k holds k quotient bits
	logic          dv_v_s5   [DIV_STEPS+1];
	logic [64:0]   dv_r_s5   [DIV_STEPS+1];
	logic [64:0]   dv_len_s5 [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] dv_q_s5 [DIV_STEPS+1];
	logic          dv_zero_s5 [DIV_STEPS+1];
	logic          dv_full_s5 [DIV_STEPS+1];
	logic [31:0]   dv_mvx_s5 [DIV_STEPS+1];
	logic [31:0]   dv_mvy_s5 [DIV_STEPS+1];
	logic          dv_svx_s5 [DIV_STEPS+1];
	logic          dv_svy_s5 [DIV_STEPS+1];
	logic signed [32:0] dv_wx_s5 [DIV_STEPS+1];
	logic signed [32:0] dv_wy_s5 [DIV_STEPS+1];

	logic          v_s6, v_s7, v_s8;
	logic [32:0]   ox_s6, oy_s6;
	logic          svx_s6, svy_s6;
	logic signed [32:0] wx_s6, wy_s6;
	logic [30:0]   mdx_s7, mdy_s7;
	logic          sat_s7, sat_s8;
	logic [61:0]   sqx_s8, sqy_s8;
	logic [63:0]   best_q;

	// centroid pipeline
	logic          cv_s1, cv_s2, cv_s3, cv_s4;
	logic [64:0]   crd_s1;
	logic [IDX_W-1:0] cidx_s1, cidx_s2, cidx_s3, cidx_s4;
	logic [31:0]   cmx_s2, cmy_s2;
	logic          csg_s2, csg_s3, csg_s4;
	logic [63:0]   csx_s3, csy_s3;
	logic [64:0]   cd_s4, cbest_q;
	logic          sign_q;

	// square root
	logic [63:0]   rt_x_q, rt_res_q, rt_bit_q, rt_sum;
	logic [30:0]   mag;
	logic          pipe_busy;

	result_t       out_q;
	logic          out_valid_q;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] n;
		n = v[32] ? 33'(-v) : 33'(v);
		return n[31:0];
	endfunction

	assign seg_n    = (seg_count_q > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : seg_count_q;
	assign cell_n   = (cell_count_q > CNT_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : cell_count_q;
	assign walk_len = (seg_n > cell_n) ? seg_n : cell_n;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_comb begin
		pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s6 | v_s7 | v_s8
			| cv_s1 | cv_s2 | cv_s3 | cv_s4;
		for (int k = 0; k <= DIV_STEPS; k++) begin
			pipe_busy = pipe_busy | dv_v_s5[k];
		end
	end

	assign rt_sum = rt_res_q + rt_bit_q;
	assign mag    = (rt_res_q > 64'(SAT_MAX)) ? SAT_MAX : rt_res_q[30:0];

	// memories: write from the input channel, read at the walk counter
	always_ff @(posedge clk) begin
		if (in_acc && in_word.req_type == REQ_SEG && int'(in_word.entry_index) < MAX_SEGMENTS) begin
			seg_mem[in_word.entry_index] <= {in_word.end_y, in_word.end_x,
				in_word.coord_y, in_word.coord_x};
		end
		if (in_acc && in_word.req_type == REQ_CELL && int'(in_word.entry_index) < MAX_CELLS) begin
			cell_mem[in_word.entry_index] <= {in_word.label_negative,
				in_word.coord_y, in_word.coord_x};
		end
		rd_s1  <= seg_mem[cnt_q[IDX_W-1:0]];
		crd_s1 <= cell_mem[cnt_q[IDX_W-1:0]];
	end

	// control: state, counts, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seg_count_q  <= CNT_W'(1);
			cell_count_q <= CNT_W'(1);
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			cv_s1 <= 1'b0; cv_s2 <= 1'b0; cv_s3 <= 1'b0; cv_s4 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				dv_v_s5[k] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEG_COUNT:  seg_count_q  <= cfg_data;
					CFG_CELL_COUNT: cell_count_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1  <= (state_q == ST_WALK) && (cnt_q < seg_n);
			cv_s1 <= (state_q == ST_WALK) && (cnt_q < cell_n);
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			dv_v_s5[0] <= v_s4;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_v_s5[k] <= dv_v_s5[k-1];
			end
			v_s6 <= dv_v_s5[DIV_STEPS]; v_s7 <= v_s6; v_s8 <= v_s7;
			cv_s2 <= cv_s1; cv_s3 <= cv_s2; cv_s4 <= cv_s3;
			// load a finished result when the output register is free, else drop a taken one
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_word.req_type == REQ_QUERY) begin
						cnt_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// advance one table entry per cycle
					if (cnt_q >= walk_len) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rt_bit_q == 64'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && in_word.req_type == REQ_QUERY) begin
			px_q    <= in_word.coord_x;
			py_q    <= in_word.coord_y;
			qidx_q  <= in_word.entry_index;
			known_q <= in_word.known_cell;
			err_q   <= in_word.known_cell ? ({1'b0, in_word.entry_index} >= cell_n)
				: (cell_n == '0);
			best_q  <= '1;
		end

		// stage 2: edge and offset vectors
		wx_s2 <= 33'(px_q) - 33'($signed(rd_s1[31:0]));
		wy_s2 <= 33'(py_q) - 33'($signed(rd_s1[63:32]));
		begin : vec
			logic signed [32:0] vx, vy, wx, wy;
			vx = 33'($signed(rd_s1[95:64])) - 33'($signed(rd_s1[31:0]));
			vy = 33'($signed(rd_s1[127:96])) - 33'($signed(rd_s1[63:32]));
			wx = 33'(px_q) - 33'($signed(rd_s1[31:0]));
			wy = 33'(py_q) - 33'($signed(rd_s1[63:32]));
			mvx_s2 <= mag33(vx); mvy_s2 <= mag33(vy);
			mwx_s2 <= mag33(wx); mwy_s2 <= mag33(wy);
			svx_s2 <= vx[32]; svy_s2 <= vy[32]; swx_s2 <= wx[32]; swy_s2 <= wy[32];
		end

		// stage 3: products
		lxx_s3 <= mvx_s2 * mvx_s2;
		lyy_s3 <= mvy_s2 * mvy_s2;
		p1_s3  <= mwx_s2 * mvx_s2;
		p2_s3  <= mwy_s2 * mvy_s2;
		n1_s3  <= swx_s2 ^ svx_s2;
		n2_s3  <= swy_s2 ^ svy_s2;
		mvx_s3 <= mvx_s2; mvy_s3 <= mvy_s2; svx_s3 <= svx_s2; svy_s3 <= svy_s2;
		wx_s3 <= wx_s2; wy_s3 <= wy_s2;

		// stage 4: squared length and dot product
		len_s4 <= 65'(lxx_s3) + 65'(lyy_s3);
		dot_s4 <= (n1_s3 ? -$signed(67'(p1_s3)) : $signed(67'(p1_s3)))
			+ (n2_s3 ? -$signed(67'(p2_s3)) : $signed(67'(p2_s3)));
		mvx_s4 <= mvx_s3; mvy_s4 <= mvy_s3; svx_s4 <= svx_s3; svy_s4 <= svy_s3;
		wx_s4 <= wx_s3; wy_s4 <= wy_s3;

		// divider setup: clamp cases of the projection parameter
		dv_zero_s5[0] <= (len_s4 == '0) || dot_s4[66] || (dot_s4 == '0);
		dv_full_s5[0] <= (dot_s4[65:0] >= 66'(len_s4));
		dv_r_s5[0]    <= dot_s4[64:0];
		dv_len_s5[0]  <= len_s4;
		dv_q_s5[0]    <= '0;
		dv_mvx_s5[0] <= mvx_s4; dv_mvy_s5[0] <= mvy_s4;
		dv_svx_s5[0] <= svx_s4; dv_svy_s5[0] <= svy_s4;
		dv_wx_s5[0]  <= wx_s4;  dv_wy_s5[0]  <= wy_s4;

		// restoring divider, one quotient bit per stage
		for (int k = 1; k <= DIV_STEPS; k++) begin
			logic [65:0] sh;
			logic ge;
			sh = {dv_r_s5[k-1], 1'b0};
			ge = (sh >= 66'(dv_len_s5[k-1]));
			dv_r_s5[k]    <= ge ? 65'(sh - 66'(dv_len_s5[k-1])) : sh[64:0];
			dv_q_s5[k]    <= {dv_q_s5[k-1][DIV_STEPS-2:0], ge};
			dv_len_s5[k]  <= dv_len_s5[k-1];
			dv_zero_s5[k] <= dv_zero_s5[k-1];
			dv_full_s5[k] <= dv_full_s5[k-1];
			dv_mvx_s5[k] <= dv_mvx_s5[k-1]; dv_mvy_s5[k] <= dv_mvy_s5[k-1];
			dv_svx_s5[k] <= dv_svx_s5[k-1]; dv_svy_s5[k] <= dv_svy_s5[k-1];
			dv_wx_s5[k]  <= dv_wx_s5[k-1];  dv_wy_s5[k]  <= dv_wy_s5[k-1];
		end

		// stage 6: offset along the segment
		begin : proj
			logic [30:0] t;
			logic [62:0] px, py;
			t = dv_zero_s5[DIV_STEPS] ? 31'd0
				: dv_full_s5[DIV_STEPS] ? (31'd1 << T_FRAC) : {1'b0, dv_q_s5[DIV_STEPS]};
			px = t * dv_mvx_s5[DIV_STEPS];
			py = t * dv_mvy_s5[DIV_STEPS];
			ox_s6 <= px[62:T_FRAC];
			oy_s6 <= py[62:T_FRAC];
		end
		svx_s6 <= dv_svx_s5[DIV_STEPS]; svy_s6 <= dv_svy_s5[DIV_STEPS];
		wx_s6  <= dv_wx_s5[DIV_STEPS];  wy_s6  <= dv_wy_s5[DIV_STEPS];

		// stage 7: residual vector, saturate large components
		begin : resid
			logic signed [34:0] dx, dy;
			logic [34:0] ax, ay;
			dx = 35'(wx_s6) - (svx_s6 ? -$signed(35'(ox_s6)) : $signed(35'(ox_s6)));
			dy = 35'(wy_s6) - (svy_s6 ? -$signed(35'(oy_s6)) : $signed(35'(oy_s6)));
			ax = dx[34] ? 35'(-dx) : 35'(dx);
			ay = dy[34] ? 35'(-dy) : 35'(dy);
			sat_s7 <= (ax > 35'(SAT_MAX)) || (ay > 35'(SAT_MAX));
			mdx_s7 <= ax[30:0];
			mdy_s7 <= ay[30:0];
		end

		// stage 8: squares
		sqx_s8 <= mdx_s7 * mdx_s7;
		sqy_s8 <= mdy_s7 * mdy_s7;
		sat_s8 <= sat_s7;

		// minimum over segments
		if (v_s8) begin
			logic [63:0] s;
			s = sat_s8 ? '1 : (64'(sqx_s8) + 64'(sqy_s8));
			if (s < best_q) begin
				best_q <= s;
			end
		end

		// centroid pipeline
		cidx_s1 <= cnt_q[IDX_W-1:0];
		cmx_s2  <= mag33(33'(px_q) - 33'($signed(crd_s1[31:0])));
		cmy_s2  <= mag33(33'(py_q) - 33'($signed(crd_s1[63:32])));
		csg_s2  <= crd_s1[64];
		cidx_s2 <= cidx_s1;
		csx_s3  <= cmx_s2 * cmx_s2;
		csy_s3  <= cmy_s2 * cmy_s2;
		csg_s3  <= csg_s2;
		cidx_s3 <= cidx_s2;
		cd_s4   <= 65'(csx_s3) + 65'(csy_s3);
		csg_s4  <= csg_s3;
		cidx_s4 <= cidx_s3;
		if (cv_s4) begin
			if (known_q) begin
				if (cidx_s4 == qidx_q) begin
					sign_q <= csg_s4;
				end
			end else if (cidx_s4 == '0 || cd_s4 < cbest_q) begin
				// first minimum wins
				cbest_q <= cd_s4;
				sign_q  <= csg_s4;
			end
		end

		// square root, one result bit per step
		if (state_q == ST_DRAIN) begin
			rt_x_q   <= best_q;
			rt_res_q <= '0;
			rt_bit_q <= 64'd1 << 62;
		end else if (state_q == ST_ROOT) begin
			if (rt_x_q >= rt_sum) begin
				rt_x_q   <= rt_x_q - rt_sum;
				rt_res_q <= (rt_res_q >> 1) + rt_bit_q;
			end else begin
				rt_res_q <= rt_res_q >> 1;
			end
			rt_bit_q <= rt_bit_q >> 2;
		end

		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_q.index_error     <= err_q;
			out_q.signed_distance <= (!err_q && sign_q) ? -$signed({1'b0, mag})
				: $signed({1'b0, mag});
		end
	end

	`CSD_ASSERT_ALWAYS(a_walk_bound, cnt_q <= CNT_W'(MAX_SEGMENTS > MAX_CELLS ? MAX_SEGMENTS : MAX_CELLS))
	`CSD_ASSERT_IMPLIES(a_err_nonneg, out_valid_q && out_q.index_error, !out_q.signed_distance[31])
	`CSD_ASSERT_IMPLIES(a_no_min_int, out_valid_q, out_q.signed_distance != 32'sh8000_0000)
endmodule
